/* hw/rtl/bdq_pkg.sv */
// Shared types and codes for the bounded deque with remove-by-value.
package bdq_pkg;

   localparam int OP_W     = 3;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [OP_W-1:0] OP_INSERT_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_REMOVE_FRONT = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE_BACK  = 3'd3;
   localparam logic [OP_W-1:0] OP_REMOVE_VALUE = 3'd4;
   localparam logic [OP_W-1:0] OP_DUMP         = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_SHF_RD,
      S_SHF_WR,
      S_RMV_END,
      S_RESP,
      S_DMP_RD,
      S_DMP_OUT
   } state_type;

endpackage

/* hw/rtl/bdq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/bounded_deque_with_remove_by_value_top.sv */
// Bounded deque of signed values with insert/remove at both ends, remove-by-value and dump.
// Insert, remove front/back, unknown codes: executed in EXEC, answered from RESP.
// Remove by value: search from head; on a match, shift later entries down, drop the tail.
// Dump: each element is read, then output, from head to tail.
// One transaction at a time; a waiting result in the output register stalls the next one.
// Reset empties the list (pointers and count cleared); stored values are not cleared.
module bounded_deque_with_remove_by_value_top #(
   parameter int CAPACITY    = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bdq_pkg::OP_W-1:0]            req_operation,
   input  logic signed [bdq_pkg::DATA_W-1:0]   req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bdq_pkg::STATUS_W-1:0]        rsp_status,
   output logic [bdq_pkg::COUNT_W-1:0]         rsp_count_after,
   output logic signed [bdq_pkg::DATA_W-1:0]   rsp_element,
   output logic                                rsp_last
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(CAPACITY);

   function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [AW-1:0] wrap_prev(input logic [AW-1:0] p);
      return (p == '0) ? LAST_SLOT : p - 1'b1;
   endfunction

   bdq_pkg::state_type state_ff, state_in;

   logic [bdq_pkg::OP_W-1:0]     op_ff, op_in;
   logic [VALUE_WIDTH-1:0]       value_ff, value_in;
   logic [bdq_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [AW-1:0]                head_ff, head_in;
   logic [AW-1:0]                tail_ff, tail_in;
   logic [AW-1:0]                pos_ff, pos_in;
   logic [AW-1:0]                dst_ff, dst_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [CW-1:0]                idx_ff, idx_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [bdq_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [bdq_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [bdq_pkg::DATA_W-1:0]   rsp_element_ff, rsp_element_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         ram_wr_en;
   logic [AW-1:0]                ram_wr_addr;
   logic [VALUE_WIDTH-1:0]       ram_wr_data;
   logic [VALUE_WIDTH-1:0]       ram_rd_data;

   logic                         out_free;
   logic                         is_full;
   logic                         is_empty;
   logic [CW-1:0]                idx_next;
   logic                         at_end;
   logic                         match;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign is_full  = (count_ff == FULL_CNT);
   assign is_empty = (count_ff == '0);
   assign idx_next = idx_ff + 1'b1;
   assign at_end   = (idx_next == count_ff);
   assign match    = (ram_rd_data == value_ff);

   bdq_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (pos_ff),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bdq_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = bdq_pkg::S_EXEC;
            end
         end
         bdq_pkg::S_EXEC: begin
            unique case (op_ff)
               bdq_pkg::OP_REMOVE_VALUE:
                  state_in = is_empty ? bdq_pkg::S_RESP : bdq_pkg::S_SRCH_RD;
               bdq_pkg::OP_DUMP:
                  state_in = is_empty ? bdq_pkg::S_RESP : bdq_pkg::S_DMP_RD;
               default:
                  state_in = bdq_pkg::S_RESP;
            endcase
         end
         bdq_pkg::S_SRCH_RD: state_in = bdq_pkg::S_SRCH_CMP;
         bdq_pkg::S_SRCH_CMP: begin
            if (match) begin
               state_in = at_end ? bdq_pkg::S_RMV_END : bdq_pkg::S_SHF_RD;
            end else begin
               state_in = at_end ? bdq_pkg::S_RESP : bdq_pkg::S_SRCH_RD;
            end
         end
         bdq_pkg::S_SHF_RD: state_in = bdq_pkg::S_SHF_WR;
         bdq_pkg::S_SHF_WR: state_in = at_end ? bdq_pkg::S_RMV_END : bdq_pkg::S_SHF_RD;
         bdq_pkg::S_RMV_END: state_in = bdq_pkg::S_RESP;
         bdq_pkg::S_RESP: begin
            if (out_free) begin
               state_in = bdq_pkg::S_IDLE;
            end
         end
         bdq_pkg::S_DMP_RD: state_in = bdq_pkg::S_DMP_OUT;
         bdq_pkg::S_DMP_OUT: begin
            if (out_free) begin
               state_in = at_end ? bdq_pkg::S_IDLE : bdq_pkg::S_DMP_RD;
            end
         end
         default: state_in = bdq_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_in          = op_ff;
      value_in       = value_ff;
      status_in      = status_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      pos_in         = pos_ff;
      dst_in         = dst_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_element_in = rsp_element_ff;
      rsp_last_in    = rsp_last_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = tail_ff;
      ram_wr_data    = value_ff;
      req_ready      = 1'b0;

      unique case (state_ff)
         bdq_pkg::S_IDLE: begin
            req_ready = 1'b1;
            op_in     = req_operation;
            value_in  = VALUE_WIDTH'(req_value);
            status_in = bdq_pkg::ST_OK;
         end
         bdq_pkg::S_EXEC: begin
            unique case (op_ff) inside
               bdq_pkg::OP_INSERT_FRONT: begin
                  if (is_full) begin
                     status_in = bdq_pkg::ST_FULL;
                  end else begin
                     head_in     = wrap_prev(head_ff);
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = wrap_prev(head_ff);
                     count_in    = count_ff + 1'b1;
                  end
               end
               bdq_pkg::OP_INSERT_BACK: begin
                  if (is_full) begin
                     status_in = bdq_pkg::ST_FULL;
                  end else begin
                     tail_in     = wrap_next(tail_ff);
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = tail_ff;
                     count_in    = count_ff + 1'b1;
                  end
               end
               bdq_pkg::OP_REMOVE_FRONT: begin
                  if (is_empty) begin
                     status_in = bdq_pkg::ST_EMPTY;
                  end else begin
                     head_in  = wrap_next(head_ff);
                     count_in = count_ff - 1'b1;
                  end
               end
               bdq_pkg::OP_REMOVE_BACK: begin
                  if (is_empty) begin
                     status_in = bdq_pkg::ST_EMPTY;
                  end else begin
                     tail_in  = wrap_prev(tail_ff);
                     count_in = count_ff - 1'b1;
                  end
               end
               bdq_pkg::OP_REMOVE_VALUE, bdq_pkg::OP_DUMP: begin
                  if (is_empty) begin
                     status_in = bdq_pkg::ST_EMPTY;
                  end else begin
                     pos_in = head_ff;
                     idx_in = '0;
                  end
               end
               default: begin
                  status_in = bdq_pkg::ST_OK;
               end
            endcase
         end
         bdq_pkg::S_SRCH_CMP: begin
            if (match) begin
               dst_in = pos_ff;
               pos_in = wrap_next(pos_ff);
               idx_in = idx_next;
            end else if (at_end) begin
               status_in = bdq_pkg::ST_NOT_FOUND;
            end else begin
               pos_in = wrap_next(pos_ff);
               idx_in = idx_next;
            end
         end
         bdq_pkg::S_SHF_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = dst_ff;
            ram_wr_data = ram_rd_data;
            dst_in      = pos_ff;
            pos_in      = wrap_next(pos_ff);
            idx_in      = idx_next;
         end
         bdq_pkg::S_RMV_END: begin
            tail_in   = wrap_prev(tail_ff);
            count_in  = count_ff - 1'b1;
            status_in = bdq_pkg::ST_OK;
         end
         bdq_pkg::S_RESP: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_count_in   = bdq_pkg::COUNT_W'(count_ff);
               rsp_element_in = '0;
               rsp_last_in    = 1'b1;
            end
         end
         bdq_pkg::S_DMP_OUT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = bdq_pkg::ST_OK;
               rsp_count_in   = bdq_pkg::COUNT_W'(count_ff);
               rsp_element_in = bdq_pkg::DATA_W'(ram_rd_data);
               rsp_last_in    = at_end;
               pos_in         = wrap_next(pos_ff);
               idx_in         = idx_next;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdq_pkg::S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      value_ff       <= value_in;
      status_ff      <= status_in;
      pos_ff         <= pos_in;
      dst_ff         <= dst_in;
      idx_ff         <= idx_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_element_ff <= rsp_element_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_count_after = rsp_count_ff;
   assign rsp_element     = $signed(rsp_element_ff);
   assign rsp_last        = rsp_last_ff;

   logic [CW:0] ptr_sum;
   logic [CW:0] ptr_wrap;

   assign ptr_sum  = (CW + 1)'(head_ff) + (CW + 1)'(count_ff);
   assign ptr_wrap = (ptr_sum >= (CW + 1)'(CAPACITY)) ? ptr_sum - (CW + 1)'(CAPACITY) : ptr_sum;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count above capacity");

   a_ptr_consistent: assert property (@(posedge clock) disable iff (reset)
      tail_ff == AW'(ptr_wrap))
      else $error("tail pointer disagrees with head plus count");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new transaction taken while one is in progress");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bdq_pkg::S_SRCH_CMP || state_ff == bdq_pkg::S_DMP_OUT)
         |-> idx_ff < count_ff)
      else $error("walk index beyond list length");

endmodule
